/* sv/cicmd_pkg.sv */
// shared constants, codes and control types of the cloud-in-cell deposit unit
package cicmd_pkg;

  localparam int GRID_SIDE  = 64;
  localparam int FRAC_BITS  = 16;
  localparam int SIDE_W     = $clog2(GRID_SIDE);
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int CELL_W     = 3 * SIDE_W;

  localparam int CMD_W      = 2;
  localparam int POS_W      = 22;
  localparam int IDX_IN_W   = 18;
  localparam int MASS_W     = 24;
  localparam int VAL_W      = 32;

  localparam int WGT_W      = FRAC_BITS + 1;
  localparam int PROD_W     = 2 * WGT_W;
  localparam int MPROD_W    = MASS_W + WGT_W;
  localparam int ADD_W      = MASS_W + 1;
  localparam int SUM_W      = VAL_W + 2;

  localparam int N_CORNERS  = 8;
  localparam int STEP_W     = $clog2(N_CORNERS) + 1;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  localparam logic [WGT_W-1:0]   ONE_FX     = WGT_W'(1) << FRAC_BITS;
  localparam logic [MASS_W-1:0]  MASS_RESET = MASS_W'(65536);
  localparam logic [VAL_W-1:0]   CELL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0]   CELL_INIT  = VAL_W'(0) - VAL_W'(ONE_FX);
  localparam logic [CELL_W-1:0]  CELL_LAST  = CELL_W'(CELL_COUNT - 1);
  localparam logic [IDX_IN_W:0]  CELL_LIMIT = (IDX_IN_W+1)'(CELL_COUNT);

  typedef struct packed {
    logic                         load;
    logic                         clr_en;
    logic                         issue;
    logic [$clog2(N_CORNERS)-1:0] corner;
    logic                         rd_cmd;
    logic                         out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic clr_last;
  } ctl_sts_t;

endpackage

/* sv/cicmd_if.sv */
// request, response and configuration channel interfaces

interface cicmd_req_if;
  import cicmd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [POS_W-1:0]    pos_z;
  logic [IDX_IN_W-1:0] cell_index;

  modport source (output valid, command, pos_x, pos_y, pos_z, cell_index, input ready);
  modport sink   (input valid, command, pos_x, pos_y, pos_z, cell_index, output ready);
endinterface

interface cicmd_rsp_if;
  import cicmd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] cell_value;
  logic                    status;

  modport source (output valid, cell_value, status, input ready);
  modport sink   (input valid, cell_value, status, output ready);
endinterface

interface cicmd_cfg_if;
  import cicmd_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASS_W-1:0] particle_mass;

  modport source (output valid, particle_mass, input ready);
  modport sink   (input valid, particle_mass, output ready);
endinterface

/* sv/cloud_in_cell_mass_deposit_unit.sv */
// Cloud-in-cell mass deposit unit: a 64x64x64 periodic density grid in one on-chip memory
// with one write and one registered read port. After reset the unit sweeps the grid to -1.0,
// one cell per cycle, and takes no request until done; a clear request repeats the sweep
// and answers when it ends. A deposit request issues its eight corners one per cycle into a
// five-stage pipeline (three rounded multiplies, memory read, saturating add and write back)
// and answers once the pipeline has drained. Each request gives exactly one response; the
// response register lets the next request in while a result waits. The particle mass
// register may be written at any time the unit holds no request in work.
module cloud_in_cell_mass_deposit_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  cicmd_req_if.sink           req_i,
  cicmd_rsp_if.source         rsp_o,
  cicmd_cfg_if.sink           cfg_i
);
  import cicmd_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  assign cfg_i.ready = 1'b1;

  cicmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_i.command),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  cicmd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .command_i    (req_i.command),
    .pos_x_i      (req_i.pos_x),
    .pos_y_i      (req_i.pos_y),
    .pos_z_i      (req_i.pos_z),
    .cell_index_i (req_i.cell_index),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_mass_i   (cfg_i.particle_mass),
    .cell_value_o (rsp_o.cell_value),
    .status_o     (rsp_o.status)
  );

endmodule

/* sv/cicmd_datapath.sv */
// grid memory, weight pipeline, clear sweep and result register
module cicmd_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cicmd_pkg::ctl_cmd_t                ctl_i,
  output cicmd_pkg::ctl_sts_t                sts_o,
  input  logic [cicmd_pkg::CMD_W-1:0]        command_i,
  input  logic [cicmd_pkg::POS_W-1:0]        pos_x_i,
  input  logic [cicmd_pkg::POS_W-1:0]        pos_y_i,
  input  logic [cicmd_pkg::POS_W-1:0]        pos_z_i,
  input  logic [cicmd_pkg::IDX_IN_W-1:0]     cell_index_i,
  input  logic                               cfg_valid_i,
  input  logic [cicmd_pkg::MASS_W-1:0]       cfg_mass_i,
  output logic signed [cicmd_pkg::VAL_W-1:0] cell_value_o,
  output logic                               status_o
);
  import cicmd_pkg::*;

  logic [VAL_W-1:0]    grid_mem_q [CELL_COUNT];

  logic [MASS_W-1:0]   mass_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [POS_W-1:0]    pos_x_q, pos_y_q, pos_z_q;
  logic [IDX_IN_W-1:0] cell_index_q;
  logic [CELL_W-1:0]   clr_addr_q, clr_addr_d;
  logic                sat_q;

  logic                v_a_q, v_b_q, v_c_q, v_d_q;
  logic [PROD_W-1:0]   p1_q, p2_q;
  logic [MPROD_W-1:0]  p3_q;
  logic [WGT_W-1:0]    wz_a_q;
  logic [ADD_W-1:0]    add_q;
  logic [CELL_W-1:0]   idx_a_q, idx_b_q, idx_c_q, idx_d_q;
  logic [VAL_W-1:0]    rdata_q;

  logic [VAL_W-1:0]    cell_value_q;
  logic                status_q;

  logic [WGT_W-1:0]    fx, fy, fz, w1, w2;
  logic [SIDE_W-1:0]   bx, by, bz, bx0, by0, bz0;
  logic [PROD_W-1:0]   r1, r2;
  logic [MPROD_W-1:0]  r3;
  logic [SUM_W-1:0]    sum;
  logic                sat;
  logic                we, re;
  logic [CELL_W-1:0]   waddr, raddr;
  logic [VAL_W-1:0]    wdata;

  // stage a: corner weights and cell address
  always_comb begin
    bx0 = pos_x_q[FRAC_BITS +: SIDE_W];
    by0 = pos_y_q[FRAC_BITS +: SIDE_W];
    bz0 = pos_z_q[FRAC_BITS +: SIDE_W];
    bx  = ctl_i.corner[0] ? bx0 + SIDE_W'(1) : bx0;
    by  = ctl_i.corner[1] ? by0 + SIDE_W'(1) : by0;
    bz  = ctl_i.corner[2] ? bz0 + SIDE_W'(1) : bz0;
    fx  = ctl_i.corner[0] ? {1'b0, pos_x_q[FRAC_BITS-1:0]}
                          : ONE_FX - {1'b0, pos_x_q[FRAC_BITS-1:0]};
    fy  = ctl_i.corner[1] ? {1'b0, pos_y_q[FRAC_BITS-1:0]}
                          : ONE_FX - {1'b0, pos_y_q[FRAC_BITS-1:0]};
    fz  = ctl_i.corner[2] ? {1'b0, pos_z_q[FRAC_BITS-1:0]}
                          : ONE_FX - {1'b0, pos_z_q[FRAC_BITS-1:0]};
  end

  // rounding, ties up
  assign r1 = p1_q + (PROD_W'(1) << (FRAC_BITS - 1));
  assign w1 = r1[FRAC_BITS +: WGT_W];
  assign r2 = p2_q + (PROD_W'(1) << (FRAC_BITS - 1));
  assign w2 = r2[FRAC_BITS +: WGT_W];
  assign r3 = p3_q + (MPROD_W'(1) << (FRAC_BITS - 1));

  // stage e: saturating accumulate
  assign sum = $signed({{(SUM_W-VAL_W){rdata_q[VAL_W-1]}}, rdata_q})
             + $signed({{(SUM_W-ADD_W){1'b0}}, add_q});
  assign sat = $signed(sum) > $signed({{(SUM_W-VAL_W){1'b0}}, CELL_MAX});

  always_comb begin
    we    = ctl_i.clr_en | v_d_q;
    waddr = ctl_i.clr_en ? clr_addr_q : idx_d_q;
    wdata = ctl_i.clr_en ? CELL_INIT : (sat ? CELL_MAX : sum[VAL_W-1:0]);
    re    = ctl_i.rd_cmd | v_c_q;
    raddr = ctl_i.rd_cmd ? cell_index_q[CELL_W-1:0] : idx_c_q;
  end

  assign clr_addr_d = (clr_addr_q == CELL_LAST) ? '0 : clr_addr_q + CELL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q     <= MASS_RESET;
      clr_addr_q <= '0;
      v_a_q      <= 1'b0;
      v_b_q      <= 1'b0;
      v_c_q      <= 1'b0;
      v_d_q      <= 1'b0;
      sat_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mass_q <= cfg_mass_i;
      end
      if (ctl_i.clr_en) begin
        clr_addr_q <= clr_addr_d;
      end
      v_a_q <= ctl_i.issue;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
      v_d_q <= v_c_q;
      if (ctl_i.load) begin
        sat_q <= 1'b0;
      end else if (v_d_q && sat) begin
        sat_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q        <= command_i;
      pos_x_q      <= pos_x_i;
      pos_y_q      <= pos_y_i;
      pos_z_q      <= pos_z_i;
      cell_index_q <= cell_index_i;
    end
    p1_q    <= fx * fy;
    wz_a_q  <= fz;
    idx_a_q <= {bz, by, bx};
    p2_q    <= w1 * wz_a_q;
    idx_b_q <= idx_a_q;
    p3_q    <= mass_q * w2;
    idx_c_q <= idx_b_q;
    add_q   <= r3[FRAC_BITS +: ADD_W];
    idx_d_q <= idx_c_q;
    if (ctl_i.out_load) begin
      cell_value_q <= (cmd_q == CMD_READ && {1'b0, cell_index_q} < CELL_LIMIT)
                      ? rdata_q : '0;
      status_q     <= (cmd_q == CMD_DEPOSIT) ? sat_q : 1'b0;
    end
  end

  // grid memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      grid_mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= grid_mem_q[raddr];
    end
  end

  assign sts_o.pipe_busy = v_a_q | v_b_q | v_c_q | v_d_q;
  assign sts_o.clr_last  = (clr_addr_q == CELL_LAST);
  assign cell_value_o    = $signed(cell_value_q);
  assign status_o        = status_q;

endmodule

/* sv/cicmd_ctrl.sv */
// command sequencer: clear sweep, corner issue, read and result handoff
module cicmd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic [cicmd_pkg::CMD_W-1:0]   req_cmd_i,
  output logic                          req_ready_o,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  input  cicmd_pkg::ctl_sts_t           sts_i,
  output cicmd_pkg::ctl_cmd_t           ctl_o
);
  import cicmd_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DEP  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              rsp_pend_q, rsp_pend_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    rsp_pend_d  = rsp_pend_q;
    req_ready_o = 1'b0;
    ctl_o       = '0;
    ctl_o.corner = step_q[STEP_W-2:0];
    case (state_q)
      ST_CLR: begin
        ctl_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = rsp_pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        step_d      = '0;
        if (req_valid_i) begin
          ctl_o.load = 1'b1;
          case (req_cmd_i)
            CMD_CLEAR: begin
              state_d    = ST_CLR;
              rsp_pend_d = 1'b1;
            end
            CMD_DEPOSIT: state_d = ST_DEP;
            CMD_READ:    state_d = ST_RD;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_DEP: begin
        if (!step_q[STEP_W-1]) begin
          ctl_o.issue = 1'b1;
          step_d      = step_q + STEP_W'(1);
        end else if (!sts_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_RD: begin
        ctl_o.rd_cmd = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          ctl_o.out_load = 1'b1;
          rsp_pend_d     = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      step_q      <= '0;
      rsp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      rsp_pend_q  <= rsp_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DEP |-> step_q <= STEP_W'(N_CORNERS))
    else $error("corner counter overran");

  a_clr_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR && sts_i.clr_last) |=> state_q != ST_CLR)
    else $error("clear sweep did not end after last cell");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |-> (!out_valid_q || rsp_ready_i))
    else $error("result register loaded while holding an untaken result");

  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.clr_en |-> !sts_i.pipe_busy)
    else $error("clear sweep overlaps deposit writes");
`endif

endmodule

/* bench/cloud_in_cell_mass_deposit_unit_test.sv */
// self-checking testbench of the cloud-in-cell mass deposit unit with a built-in grid predictor
module cloud_in_cell_mass_deposit_unit_test;
  import cicmd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 104;
  localparam int TOUCHED_MAX = 64;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    pos_z;
    logic [IDX_IN_W-1:0] cell_index;
  } cell_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic                    status;
  } cell_rsp_t;

  logic clk_i;
  logic rst_ni;

  cicmd_req_if req_if ();
  cicmd_rsp_if rsp_if ();
  cicmd_cfg_if cfg_if ();

  cloud_in_cell_mass_deposit_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  logic signed [VAL_W-1:0] density_cells [CELL_COUNT];
  logic [MASS_W-1:0]       deposit_mass;
  cell_rsp_t               expected_rsp [$];
  logic [CELL_W-1:0]       touched_cells [$];
  bit                      idle_on;
  int                      rsp_hold_left;
  int                      fail_count;

  always #5 clk_i = ~clk_i;

  function automatic u64_t round_fx(u64_t p);
    return (p + (u64_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  endfunction

  function automatic cell_rsp_t predict_response(cell_req_t rq);
    cell_rsp_t         r;
    logic [POS_W-1:0]  p [3];
    u64_t              wt [3][2];
    logic [SIDE_W-1:0] lo [3][2];
    u64_t              w;
    logic [CELL_W-1:0] slot;
    longint            sum;
    r.cell_value = '0;
    r.status = 1'b0;
    p[0] = rq.pos_x;
    p[1] = rq.pos_y;
    p[2] = rq.pos_z;
    case (rq.command)
      CMD_CLEAR: begin
        foreach (density_cells[i]) density_cells[i] = CELL_INIT;
      end
      CMD_DEPOSIT: begin
        for (int a = 0; a < 3; a++) begin
          wt[a][1] = u64_t'(p[a][FRAC_BITS-1:0]);
          wt[a][0] = (u64_t'(1) << FRAC_BITS) - wt[a][1];
          lo[a][0] = p[a][FRAC_BITS +: SIDE_W];
          lo[a][1] = lo[a][0] + SIDE_W'(1);
        end
        // corner order x fastest, then y, then z
        for (int c = 0; c < N_CORNERS; c++) begin
          w = round_fx(wt[0][c[0]] * wt[1][c[1]]);
          w = round_fx(w * wt[2][c[2]]);
          w = round_fx(u64_t'(deposit_mass) * w);
          slot = {lo[2][c[2]], lo[1][c[1]], lo[0][c[0]]};
          sum = longint'(density_cells[slot]) + longint'(w);
          if (sum > longint'(CELL_MAX)) begin
            density_cells[slot] = CELL_MAX;
            r.status = 1'b1;
          end else begin
            density_cells[slot] = sum[VAL_W-1:0];
          end
        end
      end
      CMD_READ: begin
        if (rq.cell_index < CELL_LIMIT) r.cell_value = density_cells[rq.cell_index[CELL_W-1:0]];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cell_req_t make_request(logic [CMD_W-1:0] command, logic [POS_W-1:0] x,
                                             logic [POS_W-1:0] y, logic [POS_W-1:0] z,
                                             logic [IDX_IN_W-1:0] idx);
    cell_req_t rq;
    rq.command = command;
    rq.pos_x = x;
    rq.pos_y = y;
    rq.pos_z = z;
    rq.cell_index = idx;
    return rq;
  endfunction

  function automatic logic [IDX_IN_W-1:0] cell_at(logic [SIDE_W-1:0] x, logic [SIDE_W-1:0] y,
                                                  logic [SIDE_W-1:0] z);
    return IDX_IN_W'({z, y, x});
  endfunction

  function automatic logic [POS_W-1:0] random_coord();
    logic [POS_W-1:0] c;
    c = POS_W'($urandom);
    case ($urandom_range(0, 5))
      0: c[FRAC_BITS-1:0] = '0;
      1: c[FRAC_BITS-1:0] = '1;
      2: c[FRAC_BITS-1:0] = FRAC_BITS'(1) << (FRAC_BITS - 1);
      3: c[POS_W-1:FRAC_BITS] = '1;
      default: ;
    endcase
    return c;
  endfunction

  // mostly deposits and reads around recently deposited particles
  function automatic cell_req_t random_request();
    cell_req_t         rq;
    logic [CELL_W-1:0] base;
    int unsigned       pick;
    rq = make_request(CMD_DEPOSIT, random_coord(), random_coord(), random_coord(),
                      IDX_IN_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      touched_cells.push_back({rq.pos_z[FRAC_BITS +: SIDE_W], rq.pos_y[FRAC_BITS +: SIDE_W],
                               rq.pos_x[FRAC_BITS +: SIDE_W]});
      if (touched_cells.size() > TOUCHED_MAX) void'(touched_cells.pop_front());
    end else if (pick < 95) begin
      rq.command = CMD_READ;
      if (touched_cells.size() != 0 && pick < 85) begin
        base = touched_cells[$urandom_range(0, touched_cells.size() - 1)];
        rq.cell_index = cell_at(base[SIDE_W-1:0] + SIDE_W'($urandom_range(0, 1)),
                                base[SIDE_W +: SIDE_W] + SIDE_W'($urandom_range(0, 1)),
                                base[2*SIDE_W +: SIDE_W] + SIDE_W'($urandom_range(0, 1)));
      end
    end else begin
      rq.command = CMD_NONE;
    end
    return rq;
  endfunction

  task automatic send_request(input cell_req_t rq);
    req_if.valid <= 1'b1;
    req_if.command <= rq.command;
    req_if.pos_x <= rq.pos_x;
    req_if.pos_y <= rq.pos_y;
    req_if.pos_z <= rq.pos_z;
    req_if.cell_index <= rq.cell_index;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    expected_rsp.push_back(predict_response(rq));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic deposit_at(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [POS_W-1:0] z);
    send_request(make_request(CMD_DEPOSIT, x, y, z, '0));
  endtask

  task automatic read_cell(input logic [IDX_IN_W-1:0] idx);
    send_request(make_request(CMD_READ, '0, '0, '0, idx));
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_mass(input logic [MASS_W-1:0] mass);
    drain_responses();
    cfg_if.valid <= 1'b1;
    cfg_if.particle_mass <= mass;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    deposit_mass = mass;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input bit on);
    @(negedge clk_i);
    idle_on = on;
    @(posedge clk_i);
  endtask

  task automatic hold_responses(input int cycles);
    @(negedge clk_i);
    rsp_hold_left = cycles;
    @(posedge clk_i);
  endtask

  task automatic test_reset_contents();
    read_cell('0);
    read_cell('1);
    send_request(make_request(CMD_NONE, '1, '1, '1, '1));
    read_cell('0);
  endtask

  task automatic test_deposit_corners();
    deposit_at('0, '0, '0);
    read_cell('0);
    // upper neighbours wrap to zero
    send_request(make_request(CMD_DEPOSIT, '1, '1, '1, '1));
    read_cell(cell_at('1, '1, '1));
    read_cell(cell_at('0, '0, '0));
    read_cell(cell_at('0, '1, '0));
    deposit_at(22'h0A8000, 22'h0A8000, 22'h0A8000);
    read_cell(cell_at(SIDE_W'(10), SIDE_W'(10), SIDE_W'(10)));
    read_cell(cell_at(SIDE_W'(11), SIDE_W'(11), SIDE_W'(11)));
    deposit_at(22'h3F0000, 22'h000001, 22'h208000);
    read_cell(cell_at(SIDE_W'(63), SIDE_W'(0), SIDE_W'(32)));
    read_cell(cell_at(SIDE_W'(0), SIDE_W'(1), SIDE_W'(33)));
  endtask

  task automatic test_mass_extremes();
    write_mass('0);
    deposit_at(22'h058000, 22'h058000, 22'h058000);
    read_cell(cell_at(SIDE_W'(5), SIDE_W'(5), SIDE_W'(5)));
    write_mass('1);
    deposit_at(22'h144000, 22'h144000, 22'h144000);
    read_cell(cell_at(SIDE_W'(20), SIDE_W'(20), SIDE_W'(20)));
    read_cell(cell_at(SIDE_W'(21), SIDE_W'(21), SIDE_W'(21)));
  endtask

  task automatic test_saturation();
    write_mass('1);
    repeat (130) deposit_at(22'h1E0000, 22'h1E0000, 22'h1E0000);
    read_cell(cell_at(SIDE_W'(30), SIDE_W'(30), SIDE_W'(30)));
    write_mass(MASS_RESET);
  endtask

  task automatic test_grid_clear();
    send_request(make_request(CMD_CLEAR, '1, '1, '1, '1));
    read_cell(cell_at(SIDE_W'(30), SIDE_W'(30), SIDE_W'(30)));
    read_cell('0);
    deposit_at('0, '0, '0);
    read_cell('0);
  endtask

  task automatic test_output_backpressure();
    set_idling(1'b0);
    hold_responses(HOLD_CYCLES);
    repeat (24) send_request(random_request());
    drain_responses();
    set_idling(1'b1);
  endtask

  task automatic test_random_traffic();
    logic [MASS_W-1:0] phase_mass [5];
    phase_mass[0] = MASS_W'($urandom);
    phase_mass[1] = '0;
    phase_mass[2] = '1;
    phase_mass[3] = MASS_W'($urandom_range(1, 1 << 18));
    phase_mass[4] = MASS_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      write_mass(phase_mass[ph]);
      set_idling(ph < 4);
      repeat (PHASE_ITEMS) send_request(random_request());
    end
  endtask

  initial begin : rsp_ready_drive
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_responses
    cell_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected response: cell_value %0d status %0d", rsp_if.cell_value,
               rsp_if.status);
        fail_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_if.cell_value !== want.cell_value) begin
          $error("cell_value: expected %0d, got %0d", want.cell_value, rsp_if.cell_value);
          fail_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("cloud_in_cell_mass_deposit_unit regression: fail");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_NONE;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.pos_z = '0;
    req_if.cell_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.particle_mass = MASS_RESET;
    idle_on = 1'b1;
    rsp_hold_left = 0;
    fail_count = 0;
    deposit_mass = MASS_RESET;
    foreach (density_cells[i]) density_cells[i] = CELL_INIT;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_contents();
    test_deposit_corners();
    test_mass_extremes();
    test_saturation();
    test_grid_clear();
    test_output_backpressure();
    test_random_traffic();
    drain_responses();
    repeat (20) @(posedge clk_i);
    if (expected_rsp.size() != 0) begin
      $error("%0d responses never arrived", expected_rsp.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("cloud_in_cell_mass_deposit_unit regression: pass");
    end else begin
      $display("cloud_in_cell_mass_deposit_unit regression: fail");
    end
    $finish;
  end

endmodule
